@@ hw/rtl/sbps_pkg.sv @@
// sbps_pkg: shared types, constants and codes for the symbol branch probability split block.
// No dependencies.
package sbps_pkg;

   localparam int MAX_VOCAB  = 4096;
   localparam int PROB_BITS  = 16;
   localparam int ADDR_W     = $clog2(MAX_VOCAB);
   localparam int VOCAB_W    = 13;
   localparam int MAX_LEVELS = 12;
   localparam int LVL_W      = 4;
   localparam int PART_W     = 28;
   localparam int TOT_W      = 30;
   localparam int QUO_W      = 15;
   localparam int REM_W      = 30;

   localparam logic [QUO_W-1:0] QUO_MAX  = 15'd32767;
   localparam logic [VOCAB_W-1:0] VOCAB_RESET = 13'd256;
   localparam logic [VOCAB_W-1:0] VOCAB_MIN   = 13'd2;
   localparam logic [VOCAB_W-1:0] VOCAB_MAX   = 13'd4096;
   localparam logic signed [TOT_W-1:0] TOTAL_ONE = TOT_W'(1) <<< PROB_BITS;

   // request kinds
   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_ENCODE = 1'b1;

   // result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_SYM  = 2'd1;
   localparam logic [1:0] ST_BAD_MASS = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SUM,
      S_CHECK,
      S_DIV,
      S_UPDATE,
      S_EMIT,
      S_ERR
   } state_type;

   // divider result toward the controller
   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

endpackage

@@ hw/rtl/symbol_branch_probability_split_top.sv @@
// symbol_branch_probability_split_top: controller, path walk and result buffer.
// Depends on sbps_pkg, sbps_store, sbps_div.
//
// A load transaction writes one probability; loads can stream back to back.
// An encode transaction bisects [0, vocab_size). Each level reads the left
// half's entries from the store one per cycle, then does the mass check, runs
// the divider (skipped when part >= total) and ends in an update. An encode
// has at most 12 levels. Its results are then handed out in depth order, each
// held until the receiver takes it.
// The single store read port sets the summing time. Only one encode is in
// flight; requests are held off until its last result is taken. csr writes are
// accepted at any time but must only be issued while the block is idle.
module symbol_branch_probability_split_top
   import sbps_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_type,
   input  logic [11:0]          req_prob_index,
   input  logic [15:0]          req_prob_value,
   input  logic [11:0]          req_symbol,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [14:0]          rsp_branch_probability,
   output logic                 rsp_branch_bit,
   output logic [3:0]           rsp_branch_depth,
   output logic [1:0]           rsp_status,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [VOCAB_W-1:0]   csr_vocab_size
);

   state_type state_ff, state_in;

   logic [VOCAB_W-1:0]      vocab_ff;
   logic [ADDR_W-1:0]       sym_ff;
   logic [ADDR_W-1:0]       start_ff;
   logic [VOCAB_W-1:0]      range_ff;
   logic signed [TOT_W-1:0] total_ff;
   logic [ADDR_W-1:0]       idx_ff;
   logic                    pend_ff;
   logic [PART_W-1:0]       part_ff;
   logic [QUO_W-1:0]        q_ff;
   logic [LVL_W-1:0]        n_ff;
   logic [LVL_W-1:0]        out_ff;
   logic [1:0]              err_ff;
   logic [QUO_W-1:0]        prob_buf_ff [MAX_LEVELS];
   logic                    bit_buf_ff  [MAX_LEVELS];

   logic                    req_acc, rsp_acc;
   logic                    enc_bad;
   logic [ADDR_W-1:0]       left;
   logic [VOCAB_W-1:0]      split_pt;
   logic                    go_right;
   logic [VOCAB_W-1:0]      range_next;
   logic                    sum_done;
   logic                    mass_bad;
   logic                    part_ge;
   logic                    rd_en;
   logic [PROB_BITS-1:0]    rd_data;
   logic                    div_start;
   div_rsp_type             div_rsp;

   assign req_acc  = req_valid && req_ready;
   assign rsp_acc  = rsp_valid && rsp_ready;
   assign enc_bad  = (vocab_ff < VOCAB_MIN) || (vocab_ff > VOCAB_MAX) ||
                     ({1'b0, req_symbol} >= vocab_ff);
   assign left     = range_ff[VOCAB_W-1:1];
   assign split_pt = {1'b0, start_ff} + {1'b0, left};
   assign go_right = {1'b0, sym_ff} >= split_pt;
   assign range_next = go_right ? (range_ff - {1'b0, left}) : {1'b0, left};
   assign sum_done = (idx_ff == left) && !pend_ff;
   assign mass_bad = total_ff <= 0;
   assign part_ge  = $signed({2'b00, part_ff}) >= total_ff;

   // configuration register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         vocab_ff <= VOCAB_RESET;
      end else if (csr_valid && csr_ready) begin
         vocab_ff <= csr_vocab_size;
      end
   end

   // probability store
   sbps_store u_store (
      .clock   (clock),
      .wr_en   (req_acc && (req_type == REQ_LOAD)),
      .wr_addr (req_prob_index),
      .wr_data (req_prob_value[PROB_BITS-1:0]),
      .rd_en   (rd_en),
      .rd_addr (ADDR_W'(start_ff + idx_ff)),
      .rd_data (rd_data)
   );

   // branch divider
   sbps_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .part  (part_ff),
      .total (total_ff),
      .rsp   (div_rsp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc && (req_type == REQ_ENCODE)) begin
               state_in = enc_bad ? S_ERR : S_SUM;
            end
         end
         S_SUM: begin
            if (sum_done) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            priority if (mass_bad) begin
               state_in = S_ERR;
            end else if (part_ge) begin
               state_in = S_UPDATE;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            if ((range_next > VOCAB_W'(1)) && (n_ff < LVL_W'(MAX_LEVELS - 1))) begin
               state_in = S_SUM;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (rsp_acc && rsp_last) begin
               state_in = S_IDLE;
            end
         end
         S_ERR: begin
            if (rsp_acc) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      rd_en     = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         S_IDLE:   req_ready = 1'b1;
         S_SUM:    rd_en     = idx_ff != left;
         S_CHECK:  div_start = !mass_bad && !part_ge;
         S_EMIT:   rsp_valid = 1'b1;
         S_ERR:    rsp_valid = 1'b1;
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // path walk datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         n_ff    <= '0;
         out_ff  <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               pend_ff  <= 1'b0;
               idx_ff   <= '0;
               part_ff  <= '0;
               n_ff     <= '0;
               out_ff   <= '0;
               sym_ff   <= req_symbol;
               start_ff <= '0;
               range_ff <= vocab_ff;
               total_ff <= TOTAL_ONE;
               err_ff   <= ST_BAD_SYM;
            end
            S_SUM: begin
               pend_ff <= rd_en;
               if (rd_en) begin
                  idx_ff <= idx_ff + ADDR_W'(1);
               end
               if (pend_ff) begin
                  part_ff <= part_ff + PART_W'(rd_data);
               end
            end
            S_CHECK: begin
               err_ff <= ST_BAD_MASS;
               q_ff   <= QUO_MAX;
            end
            S_DIV: begin
               if (div_rsp.done) begin
                  q_ff <= div_rsp.quotient;
               end
            end
            S_UPDATE: begin
               prob_buf_ff[n_ff] <= q_ff;
               bit_buf_ff[n_ff]  <= go_right;
               n_ff              <= n_ff + LVL_W'(1);
               range_ff          <= range_next;
               if (go_right) begin
                  start_ff <= split_pt[ADDR_W-1:0];
                  total_ff <= total_ff - $signed({2'b00, part_ff});
               end else begin
                  total_ff <= $signed({2'b00, part_ff});
               end
               idx_ff  <= '0;
               part_ff <= '0;
               pend_ff <= 1'b0;
            end
            S_EMIT: begin
               if (rsp_acc) begin
                  out_ff <= out_ff + LVL_W'(1);
               end
            end
            S_ERR: ;
            default: ;
         endcase
      end
   end

   // result channel
   always_comb begin
      if (state_ff == S_ERR) begin
         rsp_branch_probability = '0;
         rsp_branch_bit         = 1'b0;
         rsp_branch_depth       = '0;
         rsp_status             = err_ff;
         rsp_last               = 1'b1;
      end else begin
         rsp_branch_probability = prob_buf_ff[out_ff];
         rsp_branch_bit         = bit_buf_ff[out_ff];
         rsp_branch_depth       = out_ff;
         rsp_status             = ST_OK;
         rsp_last               = out_ff == (n_ff - LVL_W'(1));
      end
   end

   // checks
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while results pending");

   a_enc_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_type == REQ_ENCODE) |=> !req_ready)
      else $error("encode did not hold off requests");

   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_last && rsp_branch_depth == '0))
      else $error("error result not single");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_branch_depth < LVL_W'(MAX_LEVELS)))
      else $error("branch depth out of range");

endmodule

@@ hw/rtl/sbps_store.sv @@
// sbps_store: probability memory, one write and one registered read port.
// Depends on sbps_pkg.
module sbps_store
   import sbps_pkg::*;
(
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  logic [PROB_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_W-1:0]    rd_addr,
   output logic [PROB_BITS-1:0] rd_data
);

   logic [PROB_BITS-1:0] mem [MAX_VOCAB];
   logic [PROB_BITS-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/sbps_div.sv @@
// sbps_div: restoring divider for part*32768/total, round half to even, clamp 1..32767.
// Depends on sbps_pkg. Requires part < total and total > 0.
module sbps_div
   import sbps_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [PART_W-1:0] part,
   input  logic [TOT_W-1:0]  total,
   output div_rsp_type       rsp
);

   logic [REM_W-1:0] r_ff, r_in;
   logic [QUO_W-1:0] q_ff, q_in;
   logic [TOT_W-1:0] tot_ff, tot_in;
   logic [LVL_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [QUO_W-1:0] res_ff, res_in;

   logic [REM_W:0]   r2;
   logic             ge;
   logic             inc;
   logic [QUO_W:0]   qs;

   // one quotient bit per cycle, then rounding
   always_comb begin
      r2     = {r_ff, 1'b0};
      ge     = r2 >= {1'b0, tot_ff};
      inc    = (r2 > {1'b0, tot_ff}) || ((r2 == {1'b0, tot_ff}) && q_ff[0]);
      qs     = {1'b0, q_ff} + {{QUO_W{1'b0}}, inc};
      r_in   = r_ff;
      q_in   = q_ff;
      tot_in = tot_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      res_in  = res_ff;
      if (start) begin
         r_in    = REM_W'(part);
         q_in    = '0;
         tot_in  = total;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff == LVL_W'(QUO_W)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (qs > {1'b0, QUO_MAX}) begin
               res_in = QUO_MAX;
            end else if (qs == '0) begin
               res_in = QUO_W'(1);
            end else begin
               res_in = qs[QUO_W-1:0];
            end
         end else begin
            cnt_in = cnt_ff + LVL_W'(1);
            if (ge) begin
               r_in = REM_W'(r2 - {1'b0, tot_ff});
            end else begin
               r_in = r2[REM_W-1:0];
            end
            q_in = {q_ff[QUO_W-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff   <= r_in;
      q_ff   <= q_in;
      tot_ff <= tot_in;
      cnt_ff <= cnt_in;
      res_ff <= res_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = res_ff;

endmodule

@@ dv/symbol_branch_probability_split_tb.sv @@
// Self-checking testbench for symbol_branch_probability_split_top: loads, encodes, vocab changes.
// Depends on sbps_pkg and the block's RTL; a scoreboard class predicts the branch results.
`timescale 1ns / 1ps

module tb;
   import sbps_pkg::*;

   typedef struct packed {
      logic [14:0] prob;
      logic        bit_r;
      logic [3:0]  depth;
      logic [1:0]  status;
      logic        last;
   } branch_t;

   // Predicts branch results from its own copy of the probability store
   class branch_scoreboard;
      logic [15:0] probs [MAX_VOCAB];
      int unsigned vocab;
      branch_t     pending [$];
      int          errors;

      function void clear();
         foreach (probs[i]) begin
            probs[i] = '0;
         end
         vocab = VOCAB_RESET;
         pending.delete();
         errors = 0;
      endfunction

      // rounded split, ties to even, clamped to 1..32767
      function logic [14:0] split(longint part, longint total);
         longint num, q, r;
         num = part * 32768;
         q = num / total;
         r = num % total;
         if (2 * r > total || (2 * r == total && q[0])) q++;
         if (q < 1) q = 1;
         if (q > 32767) q = 32767;
         return q[14:0];
      endfunction

      function void note_request(logic kind, logic [11:0] idx, logic [15:0] val,
                                 logic [11:0] sym);
         branch_t b;
         branch_t path [$];
         longint start, range, total, part, half;
         int n;
         if (kind == REQ_LOAD) begin
            probs[idx] = val;
            return;
         end
         if (vocab < 2 || vocab > MAX_VOCAB || sym >= vocab) begin
            b = '{prob: 0, bit_r: 0, depth: 0, status: ST_BAD_SYM, last: 1};
            pending.insert(pending.size(), b);
            return;
         end
         start = 0;
         range = vocab;
         total = 65536;
         n = 0;
         while (range > 1 && n < MAX_LEVELS) begin
            half = range >> 1;
            part = 0;
            for (longint i = 0; i < half; i++) part += probs[start + i];
            if (total <= 0) begin
               b = '{prob: 0, bit_r: 0, depth: 0, status: ST_BAD_MASS, last: 1};
               pending.insert(pending.size(), b);
               return;
            end
            b.prob = split(part, total);
            b.bit_r = (sym >= start + half);
            b.depth = n[3:0];
            b.status = ST_OK;
            b.last = 0;
            path.insert(path.size(), b);
            n++;
            if (b.bit_r) begin
               start += half;
               range -= half;
               total -= part;
            end else begin
               range = half;
               total = part;
            end
         end
         path[path.size()-1].last = 1;
         foreach (path[i]) pending.insert(pending.size(), path[i]);
      endfunction

      function void check_branch(branch_t got);
         branch_t exp;
         if (pending.size() == 0) begin
            $error("unexpected result transaction");
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got.prob !== exp.prob) begin
            $error("branch_probability exp %0d got %0d", exp.prob, got.prob); errors++;
         end
         if (got.bit_r !== exp.bit_r) begin
            $error("branch_bit exp %0d got %0d", exp.bit_r, got.bit_r); errors++;
         end
         if (got.depth !== exp.depth) begin
            $error("branch_depth exp %0d got %0d", exp.depth, got.depth); errors++;
         end
         if (got.status !== exp.status) begin
            $error("status exp %0d got %0d", exp.status, got.status); errors++;
         end
         if (got.last !== exp.last) begin
            $error("last exp %0d got %0d", exp.last, got.last); errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_ready, req_type;
   logic [11:0] req_prob_index, req_symbol;
   logic [15:0] req_prob_value;
   logic rsp_valid, rsp_ready, rsp_branch_bit, rsp_last;
   logic [14:0] rsp_branch_probability;
   logic [3:0] rsp_branch_depth;
   logic [1:0] rsp_status;
   logic csr_valid, csr_ready;
   logic [VOCAB_W-1:0] csr_vocab_size;

   branch_scoreboard scb;
   int send_idle, recv_stall;
   bit hold_off;
   bit req_on;
   longint cycles;

   symbol_branch_probability_split_top dut (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // watchdog
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > 4000000) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // result side: random stall, long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready)
            scb.check_branch({rsp_branch_probability, rsp_branch_bit, rsp_branch_depth,
                              rsp_status, rsp_last});
         rsp_ready <= !hold_off && ($urandom_range(99) >= recv_stall);
      end
   end

   // drops valid once, only if it is still being driven high
   task automatic release_req();
      if (req_on) begin
         req_valid <= 0;
         req_on = 0;
      end
   endtask

   task automatic send(logic kind, logic [11:0] idx, logic [15:0] val, logic [11:0] sym);
      while ($urandom_range(99) < send_idle) begin
         release_req();
         @(posedge clock);
      end
      req_valid <= 1;
      req_on = 1;
      req_type <= kind;
      req_prob_index <= idx;
      req_prob_value <= val;
      req_symbol <= sym;
      do @(posedge clock); while (!req_ready);
      scb.note_request(kind, idx, val, sym);
   endtask

   task automatic load(int idx, int val);
      send(REQ_LOAD, idx[11:0], val[15:0], 12'($urandom()));
   endtask

   task automatic encode(int sym);
      send(REQ_ENCODE, 12'($urandom()), 16'($urandom()), sym[11:0]);
   endtask

   // waits for all results, then lets the block settle
   task automatic drain();
      release_req();
      while (scb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_vocab(int v);
      drain();
      csr_valid <= 1;
      csr_vocab_size <= v[VOCAB_W-1:0];
      do @(posedge clock); while (!csr_ready);
      scb.vocab = v[VOCAB_W-1:0];
      csr_valid <= 0;
   endtask

   // loads a fresh random distribution over [0, v)
   task automatic fill(int v, bit zeros);
      for (int i = 0; i < v; i++)
         load(i, zeros && ($urandom_range(3) == 0) ? 0 : $urandom_range(65535));
   endtask

   initial begin
      int v;
      scb = new();
      scb.clear();
      reset = 1;
      req_valid = 0; req_type = 0; req_prob_index = 0; req_prob_value = 0; req_symbol = 0;
      req_on = 0;
      csr_valid = 0; csr_vocab_size = 0;
      send_idle = 0; recv_stall = 0; hold_off = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: small vocabulary, extremes, ties, zero mass
      set_vocab(2);
      load(0, 16'hFFFF); load(1, 0);
      encode(0); encode(1); encode(2); encode(12'hFFF);
      load(0, 0); encode(0);
      set_vocab(4);
      load(0, 16384); load(1, 16384); load(2, 0); load(3, 65535);
      encode(0); encode(3); encode(2);
      load(0, 0); load(1, 0); encode(1);
      set_vocab(1); encode(0);
      set_vocab(0); encode(0);
      set_vocab(4097); encode(5);
      set_vocab(8191); encode(0);
      set_vocab(100);
      fill(100, 0);
      load(99, 16'hFFFF); load(99, 0);
      encode(99); encode(0); encode(50);

      // long receiver hold-off while encodes keep coming
      set_vocab(8);
      fill(8, 0);
      fork
         begin
            hold_off = 1;
            repeat (400) @(posedge clock);
            hold_off = 0;
         end
         begin
            for (int i = 0; i < 6; i++) encode($urandom_range(7));
            release_req();
         end
      join

      // random phases
      for (int ph = 0; ph < 4; ph++) begin
         send_idle = (ph == 1 || ph == 3) ? ((ph == 3) ? 14 : 47) : 0;
         recv_stall = (ph == 2 || ph == 3) ? ((ph == 3) ? 14 : 47) : 0;
         v = $urandom_range(2, 24);
         set_vocab(v);
         fill(v, ph == 2);
         for (int i = 0; i < 50; i++) begin
            if ($urandom_range(9) < 2) load($urandom_range(v - 1), $urandom_range(65535));
            else if ($urandom_range(19) == 0) encode($urandom_range(4095));
            else encode($urandom_range(v - 1));
         end
      end
      send_idle = 0; recv_stall = 0;

      drain();
      repeat (100) @(posedge clock);
      if (scb.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/sbps_pkg.sv
hw/rtl/sbps_store.sv
hw/rtl/sbps_div.sv
hw/rtl/symbol_branch_probability_split_top.sv
dv/symbol_branch_probability_split_tb.sv
